/* rtl/stq_pkg.sv */
// Package for the sorted timer queue: depth, opcodes, beat structs and cell types.
// Depends on nothing; used by every file in rtl.
package stq_pkg;
  localparam int QueueDepth = 16;
  localparam int IdxW = $clog2(QueueDepth);
  localparam int CntW = $clog2(QueueDepth + 1);
  localparam int MaxFire = 63;
  localparam logic [15:0] WaitReset = 16'd50;
  localparam logic [47:0] Mask48 = 48'hFFFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_CANCEL = 2'd1,
    OP_QUERY = 2'd2,
    OP_POLL = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_ACK = 2'd0,
    KIND_FIRED = 2'd1,
    KIND_DONE = 2'd2
  } kind_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [15:0] timer_func;
    logic [31:0] timer_context;
    logic [47:0] due_time;
    logic [47:0] current_time;
    logic repeat_req;
    logic via_message;
    logic [30:0] interval_ms;
  } in_beat_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic full_error;
    logic found;
    logic [15:0] fired_func;
    logic [31:0] fired_context;
    logic fired_via_message;
    logic [15:0] wait_ms;
    logic last;
  } out_beat_t;

  typedef struct packed {
    logic [15:0] func;
    logic [31:0] context_word;
    logic [47:0] due;
    logic rep;
    logic msg;
    logic [30:0] period;
  } entry_t;

  // Per-cycle command the sequencer broadcasts to every cell.
  typedef struct packed {
    logic ins;      // insert new_entry at the sorted slot
    logic pop;      // shift everything one toward the head
    logic del;      // remove the first cell flagged by a key match (one pass per cycle)
    entry_t new_entry;
  } cell_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD,
    ST_CANCEL,
    ST_POLL,
    ST_REINS,
    ST_DONE
  } state_t;
endpackage

/* rtl/stq_cell.sv */
// One slot of the sorted timer chain: holds an entry, takes from its left or right neighbor.
// Depends on stq_pkg.
module stq_cell (
  input  logic clk,
  input  logic rst,
  input  stq_pkg::cell_cmd_t cmd,
  input  logic left_valid,
  input  logic left_goes_after,   // left neighbor's entry is due not later than new_entry
  input  stq_pkg::entry_t left_entry,
  input  logic right_valid,
  input  stq_pkg::entry_t right_entry,
  input  logic del_here,          // this cell is the first key match
  input  logic del_left,          // a cell to the left is the first key match
  output logic valid,
  output logic goes_after,
  output logic key_hit,
  output stq_pkg::entry_t entry
);
  logic valid_next;
  stq_pkg::entry_t entry_next;

  assign goes_after = valid && (entry.due <= cmd.new_entry.due);
  assign key_hit = valid && (entry.func == cmd.new_entry.func)
                   && (entry.context_word == cmd.new_entry.context_word);

  always_comb begin
    valid_next = valid;
    entry_next = entry;
    if (cmd.ins) begin
      if (!goes_after) begin
        valid_next = left_valid || goes_after || valid || !left_valid;
        if (left_goes_after || !left_valid) begin
          entry_next = cmd.new_entry;
          valid_next = 1'b1;
        end else begin
          entry_next = left_entry;
          valid_next = left_valid;
        end
        if (!left_valid && !valid && !left_goes_after) begin
          // empty slot not directly after the tail stays empty unless it is the head
          valid_next = 1'b0;
        end
      end
    end else if (cmd.pop || (cmd.del && (del_here || del_left))) begin
      valid_next = right_valid;
      entry_next = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
    entry <= entry_next;
  end
endmodule

/* rtl/stq_chain.sv */
// Row of QueueDepth cells kept in due order, with a first-match locator for deletes.
// Depends on stq_pkg and stq_cell.
module stq_chain (
  input  logic clk,
  input  logic rst,
  input  stq_pkg::cell_cmd_t cmd,
  input  logic is_head_tail,      // when high, full is held low even with the last slot taken
  output logic any_hit,
  output logic head_valid,
  output logic full,
  output stq_pkg::entry_t head
);
  logic [stq_pkg::QueueDepth-1:0] valid, after_v, hit, del_here, del_left;
  stq_pkg::entry_t entries [stq_pkg::QueueDepth];

  always_comb begin
    logic seen;
    seen = 1'b0;
    for (int i = 0; i < stq_pkg::QueueDepth; i++) begin
      del_left[i] = seen;
      del_here[i] = hit[i] && !seen;
      seen = seen || hit[i];
    end
  end

  genvar g;
  generate
    for (g = 0; g < stq_pkg::QueueDepth; g++) begin : g_cell
      logic lv, la, rv;
      stq_pkg::entry_t le, re;
      if (g == 0) begin : g_first
        assign lv = 1'b0;
        assign la = 1'b0;
        assign le = cmd.new_entry;
      end else begin : g_mid
        assign lv = valid[g-1];
        assign la = after_v[g-1];
        assign le = entries[g-1];
      end
      if (g == stq_pkg::QueueDepth - 1) begin : g_last
        assign rv = 1'b0;
        assign re = cmd.new_entry;
      end else begin : g_next
        assign rv = valid[g+1];
        assign re = entries[g+1];
      end
      stq_cell u_cell (
        .clk(clk), .rst(rst), .cmd(cmd),
        .left_valid(g == 0 ? 1'b1 : lv),
        .left_goes_after(g == 0 ? 1'b1 : la),
        .left_entry(le), .right_valid(rv), .right_entry(re),
        .del_here(del_here[g]), .del_left(del_left[g]),
        .valid(valid[g]), .goes_after(after_v[g]), .key_hit(hit[g]),
        .entry(entries[g])
      );
    end
  endgenerate

  assign any_hit = |hit;
  assign head_valid = valid[0];
  assign head = entries[0];
  assign full = valid[stq_pkg::QueueDepth-1] && !is_head_tail;
endmodule

/* rtl/sorted_timer_queue.sv */
// Sorted timer queue: a chain of 16 cells kept in due order; the head is always cell 0.
// Beats come from ST_ADD (add), ST_DONE (query) and ST_CANCEL once every match is removed,
// one at a time; poll gives one fired beat per cycle, with ST_REINS between when a repeat is
// reinserted, then the wait beat. One item at a time: busy is high while the sequencer works
// and drops in the cycle the last beat shows; a poll fires at most 63 timers.
// Reset (rst, synchronous) empties the chain and loads max_wait_ms with 50; no receiver stall.
module sorted_timer_queue (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  stq_pkg::in_beat_t cmd_in,
  output logic strobe,
  output stq_pkg::out_beat_t result,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [2:2] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  stq_pkg::state_t state, state_next;
  stq_pkg::in_beat_t req;
  logic [15:0] max_wait_ms;
  logic [5:0] fire_cnt;
  logic hit_seen;
  stq_pkg::entry_t reins;
  stq_pkg::entry_t head_resched;
  stq_pkg::cell_cmd_t ccmd;
  logic any_hit, head_valid, full;
  stq_pkg::entry_t head;
  stq_pkg::out_beat_t beat;
  logic beat_valid;
  logic head_due;
  logic [47:0] diff;
  logic [48:0] sum;

  // Config port: a single register at offset 0.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {16'd0, max_wait_ms} : 32'd0;
  always_ff @(posedge clk) begin
    if (rst) begin
      max_wait_ms <= stq_pkg::WaitReset;
    end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
      max_wait_ms <= pwdata[15:0];
    end
  end

  assign busy = (state != stq_pkg::ST_IDLE);
  assign head_due = head_valid && (head.due <= req.current_time);
  assign diff = head.due - req.current_time;
  assign sum = {1'b0, head.due} + {18'd0, head.period};

  // Head entry rescheduled for its next period, due time saturated.
  always_comb begin
    head_resched = head;
    head_resched.due = sum[48] ? stq_pkg::Mask48 : sum[47:0];
  end

  stq_chain u_chain (
    .clk(clk), .rst(rst), .cmd(ccmd), .is_head_tail(1'b0),
    .any_hit(any_hit), .head_valid(head_valid), .full(full), .head(head)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      stq_pkg::ST_IDLE: begin
        if (start) begin
          unique case (stq_pkg::opcode_t'(cmd_in.opcode))
            stq_pkg::OP_ADD: state_next = stq_pkg::ST_ADD;
            stq_pkg::OP_CANCEL: state_next = stq_pkg::ST_CANCEL;
            stq_pkg::OP_QUERY: state_next = stq_pkg::ST_DONE;
            stq_pkg::OP_POLL: state_next = stq_pkg::ST_POLL;
            default: state_next = stq_pkg::ST_IDLE;
          endcase
        end
      end
      stq_pkg::ST_ADD: state_next = stq_pkg::ST_IDLE;
      stq_pkg::ST_CANCEL: if (!any_hit) state_next = stq_pkg::ST_IDLE;
      stq_pkg::ST_POLL: begin
        if (fire_cnt == 6'(stq_pkg::MaxFire) || !head_due) state_next = stq_pkg::ST_IDLE;
        else if (head.rep) state_next = stq_pkg::ST_REINS;
      end
      stq_pkg::ST_REINS: state_next = stq_pkg::ST_POLL;
      stq_pkg::ST_DONE: state_next = stq_pkg::ST_IDLE;
      default: state_next = stq_pkg::ST_IDLE;
    endcase
  end

  // Outputs to the chain and the result beat
  always_comb begin
    ccmd = '0;
    ccmd.new_entry.func = req.timer_func;
    ccmd.new_entry.context_word = req.timer_context;
    ccmd.new_entry.due = req.due_time;
    ccmd.new_entry.rep = req.repeat_req;
    ccmd.new_entry.msg = req.via_message;
    ccmd.new_entry.period = req.interval_ms;
    beat = '0;
    beat_valid = 1'b0;
    unique case (state)
      stq_pkg::ST_ADD: begin
        ccmd.ins = !full;
        beat.result_kind = stq_pkg::KIND_ACK;
        beat.full_error = full;
        beat.last = 1'b1;
        beat_valid = 1'b1;
      end
      stq_pkg::ST_CANCEL: begin
        ccmd.del = 1'b1;
        if (!any_hit) begin
          beat.found = hit_seen;
          beat.last = 1'b1;
          beat_valid = 1'b1;
        end
      end
      stq_pkg::ST_DONE: begin
        beat.found = any_hit;
        beat.last = 1'b1;
        beat_valid = 1'b1;
      end
      stq_pkg::ST_POLL: begin
        beat_valid = 1'b1;
        if (fire_cnt != 6'(stq_pkg::MaxFire) && head_due) begin
          ccmd.pop = 1'b1;
          beat.result_kind = stq_pkg::KIND_FIRED;
          beat.fired_func = head.func;
          beat.fired_context = head.context_word;
          beat.fired_via_message = head.msg;
        end else begin
          beat.result_kind = stq_pkg::KIND_DONE;
          beat.last = 1'b1;
          if (!head_valid) beat.wait_ms = max_wait_ms;
          else if (head_due) beat.wait_ms = 16'd0;
          else if (diff < {32'd0, max_wait_ms}) beat.wait_ms = diff[15:0];
          else beat.wait_ms = max_wait_ms;
        end
      end
      stq_pkg::ST_REINS: begin
        ccmd.ins = 1'b1;
        ccmd.new_entry = reins;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= stq_pkg::ST_IDLE;
      strobe <= 1'b0;
      fire_cnt <= '0;
      hit_seen <= 1'b0;
    end else begin
      state <= state_next;
      strobe <= beat_valid;
      if (state == stq_pkg::ST_IDLE) begin
        fire_cnt <= '0;
        hit_seen <= 1'b0;
      end else begin
        if (ccmd.pop) fire_cnt <= fire_cnt + 6'd1;
        if (any_hit) hit_seen <= 1'b1;
      end
    end
    result <= beat;
    if (state == stq_pkg::ST_IDLE && start) req <= cmd_in;
    // Capture the head for reinsert.
    if (ccmd.pop) reins <= head_resched;
  end
endmodule

/* tb/tb_top.sv */
// Self-checking bench for sorted_timer_queue: add, cancel, query and poll commands.
// Depends on rtl/stq_pkg.sv and rtl/sorted_timer_queue.sv; a built-in timer table
// predicts every result beat.
`timescale 1ns / 1ps

module tb_top;
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  stq_pkg::in_beat_t cmd_in = '0;
  logic strobe;
  stq_pkg::out_beat_t result;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:2] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  sorted_timer_queue dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd_in(cmd_in),
    .strobe(strobe), .result(result), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  always #5 clk = ~clk;

  // Shadow of the timer table and the wait clamp register.
  stq_pkg::entry_t timer_table[$];
  logic [15:0] wait_clamp = stq_pkg::WaitReset;
  stq_pkg::in_beat_t cmd_backlog[$];   // commands not yet accepted
  stq_pkg::out_beat_t due_beats[$];    // result beats still to arrive
  int errors = 0;
  logic [47:0] now_ms = '0;

  function automatic void table_insert(stq_pkg::entry_t e);
    int pos;
    pos = 0;
    // equal due times stay in arrival order: go past every entry not later
    while (pos < timer_table.size() && timer_table[pos].due <= e.due) pos++;
    timer_table.insert(pos, e);
  endfunction

  function automatic stq_pkg::out_beat_t beat(stq_pkg::kind_t k);
    stq_pkg::out_beat_t b;
    b = '0;
    b.result_kind = k;
    return b;
  endfunction

  // Apply one accepted command to the shadow table and queue its beats.
  function automatic void predict_timer_cmd(stq_pkg::in_beat_t c);
    stq_pkg::out_beat_t b;
    stq_pkg::entry_t e, h;
    logic [48:0] sum;
    int i, fired;
    bit hit;
    case (stq_pkg::opcode_t'(c.opcode))
      stq_pkg::OP_ADD: begin
        b = beat(stq_pkg::KIND_ACK);
        b.last = 1'b1;
        if (timer_table.size() >= stq_pkg::QueueDepth) begin
          b.full_error = 1'b1;   // drop the timer
        end else begin
          e.func = c.timer_func;
          e.context_word = c.timer_context;
          e.due = c.due_time;
          e.rep = c.repeat_req;
          e.msg = c.via_message;
          e.period = c.interval_ms;
          table_insert(e);
        end
        due_beats.push_back(b);
      end
      stq_pkg::OP_CANCEL, stq_pkg::OP_QUERY: begin
        hit = 1'b0;
        i = 0;
        while (i < timer_table.size()) begin
          if (timer_table[i].func == c.timer_func &&
              timer_table[i].context_word == c.timer_context) begin
            hit = 1'b1;
            if (c.opcode == stq_pkg::OP_QUERY) break;
            timer_table.delete(i);
          end else begin
            i++;
          end
        end
        b = beat(stq_pkg::KIND_ACK);
        b.found = hit;
        b.last = 1'b1;
        due_beats.push_back(b);
      end
      default: begin
        fired = 0;
        // fire at most MaxFire timers, leaving room for the closing beat
        while (fired < stq_pkg::MaxFire && timer_table.size() > 0 &&
               timer_table[0].due <= c.current_time) begin
          h = timer_table[0];
          timer_table.delete(0);
          b = beat(stq_pkg::KIND_FIRED);
          b.fired_func = h.func;
          b.fired_context = h.context_word;
          b.fired_via_message = h.msg;
          due_beats.push_back(b);
          fired++;
          if (h.rep) begin
            // saturate the rescheduled due time at the top of the 48-bit range
            sum = {1'b0, h.due} + {18'd0, h.period};
            h.due = sum[48] ? stq_pkg::Mask48 : sum[47:0];
            table_insert(h);
          end
        end
        b = beat(stq_pkg::KIND_DONE);
        b.last = 1'b1;
        b.wait_ms = wait_clamp;
        if (timer_table.size() > 0) begin
          if (timer_table[0].due <= c.current_time) b.wait_ms = '0;
          else if (timer_table[0].due - c.current_time < {32'd0, wait_clamp})
            b.wait_ms = 16'(timer_table[0].due - c.current_time);
        end
        due_beats.push_back(b);
      end
    endcase
  endfunction

  // Driver: present backlog commands in bursts with random gaps between them.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      if (start) begin
        predict_timer_cmd(cmd_in);
        cmd_backlog.delete(0);
      end
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (cmd_backlog.size() > 0) begin
        start <= 1'b1;
        cmd_in <= cmd_backlog[0];
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          // end of burst: pick the next burst and the idle stretch after it
          burst_left = $urandom_range(0, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every strobed beat must match the oldest expectation.
  stq_pkg::out_beat_t want;
  always @(posedge clk) begin
    if (!rst && strobe) begin
      if (due_beats.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat: expected none, actual %p", $realtime, result);
      end else begin
        want = due_beats[0];
        due_beats.delete(0);
        if (result !== want) begin
          errors++;
          $display("%0t: beat mismatch: expected %p, actual %p", $realtime, want, result);
        end
      end
    end
  end

  function automatic stq_pkg::in_beat_t mk(stq_pkg::opcode_t op, logic [15:0] f,
                                           logic [31:0] c, logic [47:0] due,
                                           logic [47:0] now, logic rep,
                                           logic msg, logic [30:0] per);
    stq_pkg::in_beat_t b;
    b.opcode = op;
    b.timer_func = f;
    b.timer_context = c;
    b.due_time = due;
    b.current_time = now;
    b.repeat_req = rep;
    b.via_message = msg;
    b.interval_ms = per;
    return b;
  endfunction

  function automatic logic [47:0] rand48();
    return 48'({$urandom(), $urandom()});
  endfunction

  // Hold until every command is taken, every beat is back and the block is idle.
  task automatic drain();
    do @(posedge clk);
    while (cmd_backlog.size() > 0 || start || busy || due_beats.size() > 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_wait_clamp(logic [15:0] v);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= '0;
    pwdata <= {16'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    wait_clamp = v;
  endtask

  // Random traffic: mostly keys from a small pool so cancels and queries hit.
  task automatic random_traffic(int n);
    logic [15:0] f;
    logic [31:0] c;
    logic [47:0] due;
    logic [30:0] per;
    stq_pkg::in_beat_t b;
    int k, sel;
    for (k = 0; k < n; k++) begin
      if ($urandom_range(0, 7) == 0) begin
        f = 16'($urandom());
        c = $urandom();
      end else begin
        f = 16'($urandom_range(0, 3)) | ($urandom_range(0, 1) ? 16'hFFF0 : 16'h0);
        c = 32'($urandom_range(0, 3));
      end
      due = ($urandom_range(0, 15) == 0) ? rand48() : now_ms + $urandom_range(0, 150);
      per = ($urandom_range(0, 9) == 0) ? 31'($urandom()) : 31'($urandom_range(1, 80));
      sel = $urandom_range(0, 99);
      if (sel < 40) begin
        b = mk(stq_pkg::OP_ADD, f, c, due, rand48(), $urandom_range(0, 3) == 0,
               1'($urandom()), per);
      end else if (sel < 55) begin
        b = mk(stq_pkg::OP_CANCEL, f, c, rand48(), rand48(), 1'($urandom()),
               1'($urandom()), 31'($urandom()));
      end else if (sel < 70) begin
        b = mk(stq_pkg::OP_QUERY, f, c, rand48(), rand48(), 1'($urandom()),
               1'($urandom()), 31'($urandom()));
      end else begin
        // advance time; now and then jump far or poll a stale time
        if ($urandom_range(0, 19) == 0) now_ms = rand48();
        else now_ms = now_ms + $urandom_range(0, 90);
        b = mk(stq_pkg::OP_POLL, 16'($urandom()), $urandom(), rand48(),
               ($urandom_range(0, 9) == 0) ? now_ms - 48'd40 : now_ms,
               1'($urandom()), 1'($urandom()), 31'($urandom()));
      end
      cmd_backlog.push_back(b);
    end
  endtask

  // Cancel every timer left over so each phase starts from a clean table.
  task automatic flush_table();
    foreach (timer_table[i])
      cmd_backlog.push_back(mk(stq_pkg::OP_CANCEL, timer_table[i].func,
                               timer_table[i].context_word, '0, '0, 1'b0, 1'b0, '0));
    drain();
  endtask

  initial begin
    int i;
    logic [15:0] clamp_set[3];
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty table, extremes, equal due times, full table, fire limit.
    cmd_backlog.push_back(mk(stq_pkg::OP_QUERY, 16'd0, 32'd0, '0, '0, 1'b0, 1'b0, '0));
    cmd_backlog.push_back(mk(stq_pkg::OP_POLL, 16'd0, 32'd0, '0, '0, 1'b0, 1'b0, '0));
    cmd_backlog.push_back(mk(stq_pkg::OP_ADD, 16'hFFFF, 32'hFFFF_FFFF, stq_pkg::Mask48, '0,
                             1'b1, 1'b1, 31'h7FFF_FFFF));
    for (i = 0; i < 15; i++)
      cmd_backlog.push_back(mk(stq_pkg::OP_ADD, 16'(i), 32'(i), 48'd10, '0, i[0], i[1],
                               31'd1));
    cmd_backlog.push_back(mk(stq_pkg::OP_ADD, 16'd99, 32'd99, 48'd0, '0, 1'b0, 1'b0, '0));
    cmd_backlog.push_back(mk(stq_pkg::OP_QUERY, 16'd3, 32'd3, '0, '0, 1'b0, 1'b0, '0));
    cmd_backlog.push_back(mk(stq_pkg::OP_CANCEL, 16'd3, 32'd3, '0, '0, 1'b0, 1'b0, '0));
    cmd_backlog.push_back(mk(stq_pkg::OP_CANCEL, 16'd3, 32'd3, '0, '0, 1'b0, 1'b0, '0));
    cmd_backlog.push_back(mk(stq_pkg::OP_POLL, '0, '0, '0, 48'd5, 1'b0, 1'b0, '0));
    cmd_backlog.push_back(mk(stq_pkg::OP_POLL, '0, '0, '0, stq_pkg::Mask48, 1'b0, 1'b0, '0));
    cmd_backlog.push_back(mk(stq_pkg::OP_POLL, '0, '0, '0, 48'd0, 1'b0, 1'b0, '0));
    drain();

    // Random phases under several clamp settings, the extremes among them.
    clamp_set[0] = 16'd0;
    clamp_set[1] = 16'hFFFF;
    clamp_set[2] = 16'($urandom_range(1, 300));
    for (i = 0; i < 3; i++) begin
      flush_table();
      write_wait_clamp(clamp_set[i]);
      now_ms = ($urandom_range(0, 3) == 0) ? rand48() >> 1 : 48'd0;
      random_traffic(95);
      drain();
    end

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end
endmodule

/* sorted_timer_queue.f */
rtl/stq_pkg.sv
rtl/stq_cell.sv
rtl/stq_chain.sv
rtl/sorted_timer_queue.sv
tb/tb_top.sv
